// ===== hdl/mlpp_pkg.sv =====
// shared types and constants of the memory load packet parser
package mlpp_pkg;

  // default field sizes in bytes
  localparam int unsigned IdBytesDefault    = 1;
  localparam int unsigned CountBytesDefault = 1;
  localparam int unsigned AddrBytesDefault  = 4;
  localparam int unsigned LenBytesDefault   = 2;
  localparam int unsigned CksumBytes        = 2;

  // default store depths
  localparam int unsigned BlockDepthDefault = 16;
  localparam int unsigned DataDepthDefault  = 1024;

  // register indexes of the configuration port
  localparam logic [1:0] RegMaxBlocks = 2'd0;
  localparam logic [1:0] RegMaxData   = 2'd1;
  localparam logic [1:0] RegBigEndian = 2'd2;

  // register reset values
  localparam logic [4:0]  MaxBlocksReset = 5'd16;
  localparam logic [10:0] MaxDataReset   = 11'd1024;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_BLOCK  = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_BAD_LENGTH      = 2'd1,
    ST_TOO_MANY_BLOCKS = 2'd2,
    ST_TOO_MANY_DATA   = 2'd3
  } status_e;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [9:0]  index;
    logic [7:0]  value;
    logic [31:0] start_address;
    logic [15:0] block_length;
    logic [15:0] block_checksum;
    logic [7:0]  memory_id;
    logic [7:0]  blocks_declared;
    logic        run_end;
  } mlpp_result_t;

endpackage

// ===== hdl/memory_load_packet_parser.sv =====
// memory load telecommand body parser: byte parser, data store, block table, result queue
//
// Takes one body byte per cycle. Each byte is parsed in the cycle it is accepted: header
// id, block count, then per block address, length, data bytes and a checksum word, with
// multi-byte fields assembled in the order that big_endian selects. Data bytes are written
// into the data store and finished block descriptors into the block table, one write port
// each, and every byte gives zero, one or two results (a data or block result, then the
// status on the final byte). Results go through a four-entry queue that drains one result
// per cycle; a byte is accepted while the queue holds at most two results, so the block
// runs at one byte per cycle as long as the output side takes results, and the queue depth
// sets how long it rides out a stalled output. The first error of a packet sticks and
// later bytes are dropped until the final byte, which reports the status and restarts the
// parser. Configuration writes are taken in any cycle and apply to bytes that follow.
module memory_load_packet_parser
  import mlpp_pkg::*;
#(
  parameter int unsigned ID_BYTES    = IdBytesDefault,
  parameter int unsigned COUNT_BYTES = CountBytesDefault,
  parameter int unsigned ADDR_BYTES  = AddrBytesDefault,
  parameter int unsigned LEN_BYTES   = LenBytesDefault,
  parameter int unsigned BLOCK_DEPTH = BlockDepthDefault,
  parameter int unsigned DATA_DEPTH  = DataDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  // body bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  raw_byte_i,
  input  logic        final_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [9:0]  index_o,
  output logic [7:0]  value_o,
  output logic [31:0] start_address_o,
  output logic [15:0] block_length_o,
  output logic [15:0] block_checksum_o,
  output logic [7:0]  memory_id_o,
  output logic [7:0]  blocks_declared_o,
  output logic        run_end_o
);

  localparam int unsigned DaW = $clog2(DATA_DEPTH);
  localparam int unsigned BiW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

  typedef enum logic [2:0] {
    PH_ID    = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CKSUM = 3'd5,
    PH_DONE  = 3'd6,
    PH_ERR   = 3'd7
  } phase_e;

  // configuration registers
  logic [4:0]  max_blocks_q;
  logic [10:0] max_data_q;
  logic        big_endian_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [31:0] asm_q, asm_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  declared_q, declared_d;
  logic [7:0]  block_index_q, block_index_d;
  logic [10:0] data_count_q, data_count_d;
  logic [15:0] bytes_left_q, bytes_left_d;
  logic [31:0] start_q, start_d;
  logic [15:0] length_q, length_d;
  status_e     err_q, err_d;

  // stores, written only
  logic [7:0]  data_store_q [DATA_DEPTH];
  logic [63:0] block_table_q [BLOCK_DEPTH];

  logic            ds_we;
  logic [DaW-1:0]  ds_addr;
  logic            bt_we;
  logic [BiW-1:0]  bt_addr;
  logic [15:0]     cksum;

  // result queue
  mlpp_result_t    rq_q [4];
  logic [1:0]      rq_wr_q, rq_rd_q;
  logic [2:0]      rq_cnt_q;
  mlpp_result_t    res_a, res_b;
  logic [1:0]      push_n;
  logic            pop;
  logic            in_fire;

  // field assembly
  logic [63:0]     le_shift;
  logic [31:0]     take_asm;
  logic [3:0]      fbc_inc;
  logic [3:0]      width_sel;
  logic            field_done;
  logic [15:0]     blk_lim;
  logic [32:0]     data_lim;
  logic [32:0]     data_sum;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (rq_cnt_q <= 3'd2);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = (rq_cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;

  assign le_shift = 64'(raw_byte_i) << {fbc_q, 3'b000};
  assign take_asm = big_endian_q ? {asm_q[23:0], raw_byte_i} : (asm_q | le_shift[31:0]);
  assign fbc_inc  = 4'(fbc_q) + 4'd1;

  always_comb begin
    unique case (phase_q)
      PH_ID:    width_sel = 4'(ID_BYTES);
      PH_COUNT: width_sel = 4'(COUNT_BYTES);
      PH_ADDR:  width_sel = 4'(ADDR_BYTES);
      PH_LEN:   width_sel = 4'(LEN_BYTES);
      default:  width_sel = 4'(CksumBytes);
    endcase
  end

  assign field_done = (fbc_inc >= width_sel);
  assign blk_lim  = (16'(max_blocks_q) < 16'(BLOCK_DEPTH)) ? 16'(max_blocks_q)
                                                           : 16'(BLOCK_DEPTH);
  assign data_lim = (33'(max_data_q) < 33'(DATA_DEPTH)) ? 33'(max_data_q)
                                                        : 33'(DATA_DEPTH);
  assign data_sum = 33'(data_count_q) + 33'(take_asm);
  assign cksum    = take_asm[15:0];
  assign ds_addr  = DaW'(data_count_q);
  assign bt_addr  = BiW'(block_index_q);

  // one byte of parsing
  always_comb begin
    mlpp_result_t first_res;
    logic         has_first;
    phase_e       ph;
    status_e      fin_status;

    phase_d       = phase_q;
    fbc_d         = fbc_q;
    asm_d         = asm_q;
    id_d          = id_q;
    declared_d    = declared_q;
    block_index_d = block_index_q;
    data_count_d  = data_count_q;
    bytes_left_d  = bytes_left_q;
    start_d       = start_q;
    length_d      = length_q;
    err_d         = err_q;
    ds_we         = 1'b0;
    bt_we         = 1'b0;
    first_res     = '0;
    has_first     = 1'b0;
    res_a         = '0;
    res_b         = '0;
    push_n        = 2'd0;
    ph            = phase_q;
    fin_status    = ST_OK;

    // a body that ends inside the header is short
    if (final_byte_i && (phase_q == PH_ID || phase_q == PH_COUNT)) begin
      if (err_d == ST_OK) err_d = ST_BAD_LENGTH;
      ph = PH_ERR;
    end

    if (ph == PH_ID || ph == PH_COUNT || ph == PH_ADDR || ph == PH_LEN || ph == PH_CKSUM) begin
      fbc_d = field_done ? 3'd0 : fbc_inc[2:0];
      asm_d = field_done ? 32'd0 : take_asm;
    end

    unique case (ph)
      PH_ID: begin
        if (field_done) begin
          id_d = take_asm[7:0];
          ph   = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (field_done) begin
          declared_d = take_asm[7:0];
          if (take_asm[15:0] > blk_lim) begin
            if (err_d == ST_OK) err_d = ST_TOO_MANY_BLOCKS;
            ph = PH_ERR;
          end else begin
            ph = (take_asm[15:0] == 16'd0) ? PH_DONE : PH_ADDR;
          end
        end
      end
      PH_ADDR: begin
        if (field_done) begin
          start_d = take_asm;
          ph      = PH_LEN;
        end
      end
      PH_LEN: begin
        if (field_done) begin
          if (data_sum > data_lim) begin
            if (err_d == ST_OK) err_d = ST_TOO_MANY_DATA;
            ph = PH_ERR;
          end else begin
            length_d     = take_asm[15:0];
            bytes_left_d = take_asm[15:0];
            ph = (take_asm[15:0] == 16'd0) ? PH_CKSUM : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        ds_we                     = 1'b1;
        has_first                 = 1'b1;
        first_res.kind            = KIND_DATA;
        first_res.status          = ST_OK;
        first_res.index           = data_count_q[9:0];
        first_res.value           = raw_byte_i;
        first_res.memory_id       = id_q;
        first_res.blocks_declared = declared_q;
        data_count_d              = data_count_q + 11'd1;
        bytes_left_d              = bytes_left_q - 16'd1;
        if (bytes_left_q == 16'd1) ph = PH_CKSUM;
      end
      PH_CKSUM: begin
        if (field_done) begin
          bt_we                     = 1'b1;
          has_first                 = 1'b1;
          first_res.kind            = KIND_BLOCK;
          first_res.status          = ST_OK;
          first_res.index           = 10'(block_index_q);
          first_res.start_address   = start_q;
          first_res.block_length    = length_q;
          first_res.block_checksum  = cksum;
          first_res.memory_id       = id_q;
          first_res.blocks_declared = declared_q;
          block_index_d             = block_index_q + 8'd1;
          ph = (9'(block_index_q) + 9'd1 >= 9'(declared_q)) ? PH_DONE : PH_ADDR;
        end
      end
      PH_DONE: begin
        // bytes past the last checksum
        if (err_d == ST_OK) err_d = ST_BAD_LENGTH;
        ph = PH_ERR;
      end
      default: begin
      end
    endcase
    phase_d = ph;

    if (final_byte_i) begin
      fin_status = (err_d == ST_OK && ph != PH_DONE) ? ST_BAD_LENGTH : err_d;
      if (has_first) begin
        res_a         = first_res;
        res_b         = '0;
        res_b.kind    = KIND_STATUS;
        res_b.status  = fin_status;
        res_b.index   = 10'(block_index_d);
        res_b.memory_id       = id_d;
        res_b.blocks_declared = declared_d;
        res_b.run_end = 1'b1;
        push_n        = 2'd2;
      end else begin
        res_a         = '0;
        res_a.kind    = KIND_STATUS;
        res_a.status  = fin_status;
        res_a.index   = 10'(block_index_d);
        res_a.memory_id       = id_d;
        res_a.blocks_declared = declared_d;
        res_a.run_end = 1'b1;
        push_n        = 2'd1;
      end
      // start of the next packet
      phase_d       = PH_ID;
      fbc_d         = 3'd0;
      asm_d         = 32'd0;
      id_d          = 8'd0;
      declared_d    = 8'd0;
      block_index_d = 8'd0;
      data_count_d  = 11'd0;
      bytes_left_d  = 16'd0;
      start_d       = 32'd0;
      length_d      = 16'd0;
      err_d         = ST_OK;
    end else if (has_first) begin
      res_a         = first_res;
      res_a.run_end = 1'b1;
      push_n        = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_blocks_q <= MaxBlocksReset;
      max_data_q   <= MaxDataReset;
      big_endian_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegMaxBlocks: max_blocks_q <= cfg_data_i[4:0];
        RegMaxData:   max_data_q   <= cfg_data_i;
        RegBigEndian: big_endian_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_ID;
      fbc_q         <= 3'd0;
      asm_q         <= 32'd0;
      id_q          <= 8'd0;
      declared_q    <= 8'd0;
      block_index_q <= 8'd0;
      data_count_q  <= 11'd0;
      bytes_left_q  <= 16'd0;
      start_q       <= 32'd0;
      length_q      <= 16'd0;
      err_q         <= ST_OK;
    end else if (in_fire) begin
      phase_q       <= phase_d;
      fbc_q         <= fbc_d;
      asm_q         <= asm_d;
      id_q          <= id_d;
      declared_q    <= declared_d;
      block_index_q <= block_index_d;
      data_count_q  <= data_count_d;
      bytes_left_q  <= bytes_left_d;
      start_q       <= start_d;
      length_q      <= length_d;
      err_q         <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && ds_we) begin
      data_store_q[ds_addr] <= raw_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && bt_we) begin
      block_table_q[bt_addr] <= {cksum, length_q, start_q};
    end
  end

  // result queue payload
  always_ff @(posedge clk_i) begin
    if (in_fire && push_n != 2'd0) begin
      rq_q[rq_wr_q] <= res_a;
      if (push_n == 2'd2) rq_q[rq_wr_q + 2'd1] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 2'd0;
      rq_rd_q  <= 2'd0;
      rq_cnt_q <= 3'd0;
    end else begin
      if (in_fire) rq_wr_q <= rq_wr_q + push_n;
      if (pop) rq_rd_q <= rq_rd_q + 2'd1;
      rq_cnt_q <= rq_cnt_q + (in_fire ? 3'(push_n) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  assign kind_o            = rq_q[rq_rd_q].kind;
  assign status_o          = rq_q[rq_rd_q].status;
  assign index_o           = rq_q[rq_rd_q].index;
  assign value_o           = rq_q[rq_rd_q].value;
  assign start_address_o   = rq_q[rq_rd_q].start_address;
  assign block_length_o    = rq_q[rq_rd_q].block_length;
  assign block_checksum_o  = rq_q[rq_rd_q].block_checksum;
  assign memory_id_o       = rq_q[rq_rd_q].memory_id;
  assign blocks_declared_o = rq_q[rq_rd_q].blocks_declared;
  assign run_end_o         = rq_q[rq_rd_q].run_end;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= 3'd4)
    else $error("result queue overflow");

  a_final_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && final_byte_i |=> phase_q == PH_ID && data_count_q == 11'd0 && err_q == ST_OK)
    else $error("parser did not restart after final byte");

  a_data_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    33'(data_count_q) <= 33'(DATA_DEPTH))
    else $error("data count past store depth");

  a_block_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ADDR |-> block_index_q < declared_q)
    else $error("address phase with no block left");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> bytes_left_q != 16'd0)
    else $error("data phase with no bytes left");
`endif

endmodule

// ===== tb/tb_memory_load_packet_parser.sv =====
// self-checking testbench of the memory load packet parser with a byte-level parse predictor
module tb_memory_load_packet_parser
  import mlpp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned REPORT_CAP = 40;
  localparam int unsigned PHASE_BEATS = 100;

  typedef enum logic [2:0] {
    PS_ID, PS_COUNT, PS_ADDR, PS_LEN, PS_DATA, PS_CKSUM, PS_DONE, PS_ERR
  } parse_state_e;

  typedef enum logic [1:0] {
    FORM_CLEAN, FORM_CUT, FORM_EXTRA, FORM_NOISE
  } packet_form_e;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } body_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] raw_byte = '0;
  logic       final_byte = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [1:0]  out_status;
  logic [9:0]  out_index;
  logic [7:0]  out_value;
  logic [31:0] out_start;
  logic [15:0] out_length;
  logic [15:0] out_checksum;
  logic [7:0]  out_memory_id;
  logic [7:0]  out_blocks;
  logic        out_run_end;

  memory_load_packet_parser dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .raw_byte_i       (raw_byte),
    .final_byte_i     (final_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (out_kind),
    .status_o         (out_status),
    .index_o          (out_index),
    .value_o          (out_value),
    .start_address_o  (out_start),
    .block_length_o   (out_length),
    .block_checksum_o (out_checksum),
    .memory_id_o      (out_memory_id),
    .blocks_declared_o(out_blocks),
    .run_end_o        (out_run_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies
  logic [4:0]  cfg_max_blocks = MaxBlocksReset;
  logic [10:0] cfg_max_data = MaxDataReset;
  logic        cfg_big_endian = 1'b0;

  // parser state copy
  parse_state_e pstate = PS_ID;
  int unsigned  field_pos = 0;
  logic [63:0]  field_acc = '0;
  logic [7:0]   id_q = '0;
  logic [15:0]  blocks_q = '0;
  int unsigned  blk_idx = 0;
  int unsigned  data_cnt = 0;
  int unsigned  bytes_left = 0;
  logic [31:0]  cur_start = '0;
  logic [15:0]  cur_len = '0;
  status_e      err_code = ST_OK;

  mlpp_result_t parse_results_due[$];
  body_beat_t   body_beats[$];
  logic [7:0]   packet_bytes[$];
  int unsigned  beats_queued = 0;
  int unsigned  errors = 0;
  int unsigned  cycle_count = 0;

  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_draw;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  body_beat_t  next_beat;

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void restart_packet();
    pstate = PS_ID;
    field_pos = 0;
    field_acc = '0;
    id_q = '0;
    blocks_q = '0;
    blk_idx = 0;
    data_cnt = 0;
    bytes_left = 0;
    cur_start = '0;
    cur_len = '0;
    err_code = ST_OK;
  endfunction

  function automatic void raise_error(input status_e code);
    if (err_code == ST_OK) err_code = code;
    pstate = PS_ERR;
  endfunction

  // returns 1 when the field under assembly is complete
  function automatic bit absorb(input logic [7:0] b, input int unsigned width);
    if (cfg_big_endian) field_acc = (field_acc << 8) | 64'(b);
    else field_acc = field_acc | (64'(b) << ((8 * field_pos) & 63));
    field_pos++;
    if (field_pos >= width) begin
      field_pos = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mlpp_result_t make_result(input kind_e k, input status_e s,
                                               input logic [9:0] idx, input logic [7:0] v,
                                               input logic [31:0] st, input logic [15:0] len,
                                               input logic [15:0] ck);
    mlpp_result_t r;
    r.kind = k;
    r.status = s;
    r.index = idx;
    r.value = v;
    r.start_address = st;
    r.block_length = len;
    r.block_checksum = ck;
    r.memory_id = id_q;
    r.blocks_declared = blocks_q[7:0];
    r.run_end = 1'b0;
    return r;
  endfunction

  task automatic parse_beat(input logic [7:0] b, input logic fin);
    mlpp_result_t step_out [2];
    int unsigned  n_out;
    logic [31:0]  limit;
    logic [31:0]  len_val;
    n_out = 0;
    if (fin && (pstate == PS_ID || pstate == PS_COUNT)) raise_error(ST_BAD_LENGTH);
    case (pstate)
      PS_ID: if (absorb(b, IdBytesDefault)) begin
        id_q = field_acc[7:0];
        field_acc = '0;
        pstate = PS_COUNT;
      end
      PS_COUNT: if (absorb(b, CountBytesDefault)) begin
        limit = (cfg_max_blocks < BlockDepthDefault) ? 32'(cfg_max_blocks) : BlockDepthDefault;
        blocks_q = field_acc[15:0];
        field_acc = '0;
        if (32'(blocks_q) > limit) raise_error(ST_TOO_MANY_BLOCKS);
        else pstate = (blocks_q == 0) ? PS_DONE : PS_ADDR;
      end
      PS_ADDR: if (absorb(b, AddrBytesDefault)) begin
        cur_start = field_acc[31:0];
        field_acc = '0;
        pstate = PS_LEN;
      end
      PS_LEN: if (absorb(b, LenBytesDefault)) begin
        len_val = field_acc[31:0];
        limit = (cfg_max_data < DataDepthDefault) ? 32'(cfg_max_data) : DataDepthDefault;
        field_acc = '0;
        if (64'(data_cnt) + 64'(len_val) > 64'(limit)) raise_error(ST_TOO_MANY_DATA);
        else begin
          cur_len = len_val[15:0];
          bytes_left = len_val;
          pstate = (bytes_left == 0) ? PS_CKSUM : PS_DATA;
        end
      end
      PS_DATA: begin
        step_out[n_out] = make_result(KIND_DATA, ST_OK, data_cnt[9:0], b, '0, '0, '0);
        n_out++;
        data_cnt++;
        bytes_left--;
        if (bytes_left == 0) pstate = PS_CKSUM;
      end
      PS_CKSUM: if (absorb(b, CksumBytes)) begin
        step_out[n_out] = make_result(KIND_BLOCK, ST_OK, blk_idx[9:0], '0, cur_start,
                                      cur_len, field_acc[15:0]);
        n_out++;
        field_acc = '0;
        blk_idx++;
        pstate = (blk_idx >= 32'(blocks_q)) ? PS_DONE : PS_ADDR;
      end
      PS_DONE: raise_error(ST_BAD_LENGTH);
      default: ;
    endcase
    if (fin) begin
      if (err_code == ST_OK && pstate != PS_DONE) err_code = ST_BAD_LENGTH;
      step_out[n_out] = make_result(KIND_STATUS, err_code, blk_idx[9:0], '0, '0, '0, '0);
      n_out++;
      restart_packet();
    end
    if (n_out > 0) step_out[n_out - 1].run_end = 1'b1;
    for (int i = 0; i < n_out; i++) parse_results_due.push_back(step_out[i]);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      if (errors < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result();
    mlpp_result_t want;
    if (parse_results_due.size() == 0) begin
      if (errors < REPORT_CAP)
        $display("%0t: result with nothing expected, expected none, actual kind %0h index %0h",
                 $time, out_kind, out_index);
      errors++;
    end else begin
      want = parse_results_due.pop_front();
      check_field("kind", 32'(want.kind), 32'(out_kind));
      check_field("status", 32'(want.status), 32'(out_status));
      check_field("index", 32'(want.index), 32'(out_index));
      check_field("value", 32'(want.value), 32'(out_value));
      check_field("start_address", want.start_address, out_start);
      check_field("block_length", 32'(want.block_length), 32'(out_length));
      check_field("block_checksum", 32'(want.block_checksum), 32'(out_checksum));
      check_field("memory_id", 32'(want.memory_id), 32'(out_memory_id));
      check_field("blocks_declared", 32'(want.blocks_declared), 32'(out_blocks));
      check_field("run_end", 32'(want.run_end), 32'(out_run_end));
    end
  endtask

  // body byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (body_beats.size() > 0) begin
        next_beat = body_beats.pop_front();
        in_valid <= 1'b1;
        raw_byte <= next_beat.octet;
        final_byte <= next_beat.last;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        gap_left <= draw_wait(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predicts on each body beat, checks each result beat, stalls the output
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (in_valid && in_ready) parse_beat(raw_byte, final_byte);
      if (out_valid && out_ready) begin
        check_result();
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
        stall_draw = draw_wait(recv_quiet);
        stall_left <= stall_draw;
        out_ready <= (stall_draw == 0);
      end else if (!out_ready) begin
        out_ready <= (stall_left <= 1);
        if (stall_left > 0) stall_left <= stall_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegMaxBlocks: cfg_max_blocks = data[4:0];
      RegMaxData:   cfg_max_data = data;
      RegBigEndian: cfg_big_endian = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic push_field(input logic [31:0] value, input int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if (cfg_big_endian) packet_bytes.push_back(8'(value >> (8 * (nbytes - 1 - i))));
      else packet_bytes.push_back(8'(value >> (8 * i)));
    end
  endtask

  // moves the assembled packet to the driver, final flag on its last byte and, with stray_ends, on random bytes too
  task automatic flush_packet(input bit stray_ends);
    body_beat_t beat;
    while (packet_bytes.size() > 0) begin
      beat.octet = packet_bytes.pop_front();
      beat.last = (packet_bytes.size() == 0) || (stray_ends && $urandom_range(0, 7) == 0);
      body_beats.push_back(beat);
      beats_queued++;
    end
  endtask

  task automatic queue_packet(input int unsigned nblk, input int unsigned min_len,
                              input int unsigned max_len, input packet_form_e form);
    int unsigned built;
    int unsigned len;
    int unsigned keep;
    if (form == FORM_NOISE) begin
      repeat ($urandom_range(1, 16)) packet_bytes.push_back(8'($urandom));
    end else begin
      push_field($urandom, IdBytesDefault);
      push_field(nblk, CountBytesDefault);
      // counts above the table depth fail at the count byte anyway
      built = (nblk > BlockDepthDefault) ? 1 : nblk;
      for (int i = 0; i < built; i++) begin
        push_field($urandom, AddrBytesDefault);
        len = $urandom_range(min_len, max_len);
        push_field(len, LenBytesDefault);
        repeat (len) packet_bytes.push_back(8'($urandom));
        push_field($urandom_range(0, 65535), CksumBytes);
      end
      if (form == FORM_CUT) begin
        keep = $urandom_range(1, packet_bytes.size());
        while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
      end else if (form == FORM_EXTRA) begin
        repeat ($urandom_range(1, 3)) packet_bytes.push_back(8'($urandom));
      end
    end
    flush_packet(form == FORM_NOISE);
  endtask

  task automatic wait_drained();
    while (body_beats.size() != 0 || in_valid || parse_results_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [10:0]  mb_w;
    logic [10:0]  md_w;
    logic [10:0]  be_w;
    int unsigned  max_len;
    int unsigned  phase_start;
    int unsigned  pick;
    int unsigned  nblk;
    packet_form_e form;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // final byte inside the id field
    push_field(8'h5A, 1);
    flush_packet(1'b0);
    // final byte inside the count field
    push_field(8'h00, 1);
    push_field(8'h01, 1);
    flush_packet(1'b0);
    // zero block count followed by one more byte
    push_field(8'hFF, 1);
    push_field(8'h00, 1);
    push_field(8'h33, 1);
    flush_packet(1'b0);
    // count just above the table depth
    push_field(8'h12, 1);
    push_field(BlockDepthDefault + 1, 1);
    push_field(8'hAB, 1);
    flush_packet(1'b0);
    // one block of one byte, with all-ones id, address, data and checksum
    push_field(8'hFF, 1);
    push_field(1, 1);
    push_field(32'hFFFF_FFFF, 4);
    push_field(1, 2);
    push_field(8'hFF, 1);
    push_field(16'hFFFF, 2);
    flush_packet(1'b0);
    // block length one past the data limit
    push_field(8'h00, 1);
    push_field(1, 1);
    push_field(32'h0, 4);
    push_field(DataDepthDefault + 1, 2);
    push_field(8'h00, 1);
    flush_packet(1'b0);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin mb_w = 11'd3; md_w = 11'd40; be_w = 11'd1; max_len = 12; end
        1: begin mb_w = 11'd0; md_w = 11'd0; be_w = 11'd0; max_len = 3; end
        2: begin mb_w = 11'd31; md_w = 11'd2047; be_w = 11'd1; max_len = 8; end
        3: begin
          mb_w = 11'($urandom_range(0, 2047));
          md_w = 11'($urandom_range(0, 2047));
          be_w = 11'($urandom_range(0, 2047));
          max_len = 10;
        end
        default: begin mb_w = 11'd16; md_w = 11'd1024; be_w = 11'd0; max_len = 8; end
      endcase
      write_reg(RegMaxBlocks, mb_w);
      write_reg(RegMaxData, md_w);
      write_reg(RegBigEndian, be_w);

      phase_start = beats_queued;
      while (beats_queued - phase_start < PHASE_BEATS) begin
        pick = $urandom_range(0, 9);
        form = (pick < 7) ? FORM_CLEAN : (pick == 7) ? FORM_CUT
             : (pick == 8) ? FORM_EXTRA : FORM_NOISE;
        nblk = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
        queue_packet(nblk, 0, max_len, form);
      end
      // one packet whose data total lands exactly on the data limit
      if (ph == 0) queue_packet(2, 20, 20, FORM_CLEAN);
      wait_drained();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mlpp_pkg.sv
hdl/memory_load_packet_parser.sv
tb/tb_memory_load_packet_parser.sv
